/* rtl/dvps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dvps_pkg;

  localparam int MAX_AXES     = 3;
  localparam int AXES_DEFAULT = 3;
  localparam int WORD_W       = 32;
  localparam int DT_W         = 24;
  localparam int MASS_W       = 24;
  localparam int IN_W         = MAX_AXES * WORD_W + DT_W;
  localparam int OUT_W        = 2 * MAX_AXES * WORD_W;
  localparam int CFG_W        = 32;
  localparam int CFG_IDX_W    = 3;

  // 0.999 in unsigned Q0.24
  localparam logic [DT_W-1:0]   DAMP_Q24       = 24'd16760439;
  localparam logic [MASS_W-1:0] INV_MASS_RESET = 24'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PINNED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASS = 3'd4;

  typedef enum logic [1:0] {
    CMD_FORCE   = 2'd0,
    CMD_GRAD    = 2'd1,
    CMD_STEP    = 2'd2,
    CMD_RESTORE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic prod_en;
    logic mul_en;
    logic upd_en;
    cmd_t cmd;
    logic pinned;
  } lane_ctl_t;

endpackage

`default_nettype wire

/* rtl/dvps_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

// One axis: position channel (0) and gradient channel (1).
module dvps_lane (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire dvps_pkg::lane_ctl_t               ctl,
  input  wire logic signed [dvps_pkg::WORD_W-1:0] vec,
  input  wire logic        [dvps_pkg::MASS_W-1:0] inv_mass,
  input  wire logic        [dvps_pkg::DT_W-1:0]   dt2,
  input  wire logic signed [dvps_pkg::WORD_W-1:0] init,
  output logic signed      [dvps_pkg::WORD_W-1:0] pos,
  output logic signed      [dvps_pkg::WORD_W-1:0] grad
);

  localparam logic signed [57:0] MAXV   = 58'sd2147483647;
  localparam logic signed [57:0] MINV   = -58'sd2147483648;
  localparam logic signed [56:0] HALF16 = 57'sd32768;
  localparam logic signed [57:0] HALF24 = 58'sd8388608;
  localparam logic signed [24:0] DAMP_S = signed'({1'b0, dvps_pkg::DAMP_Q24});

  function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
    logic signed [31:0] r;
    if (v > MAXV) begin
      r = 32'sh7FFFFFFF;
    end else if (v < MINV) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [31:0] cur  [2];
  logic signed [31:0] prev [2];
  logic signed [31:0] acc  [2];
  logic signed [56:0] prod;
  logic signed [57:0] md   [2];
  logic signed [57:0] mp   [2];

  logic signed [24:0] im_s;
  logic signed [24:0] dt2_s;
  logic signed [32:0] dpos [2];
  logic signed [31:0] nxt  [2];
  logic signed [56:0] prod_rnd;
  logic signed [31:0] term;
  logic signed [31:0] acc_upd;
  logic               sel;
  logic               is_force;

  assign im_s     = signed'({1'b0, inv_mass});
  assign dt2_s    = signed'({1'b0, dt2});
  assign sel      = (ctl.cmd == dvps_pkg::CMD_GRAD);
  assign is_force = (ctl.cmd == dvps_pkg::CMD_FORCE) || (ctl.cmd == dvps_pkg::CMD_GRAD);
  assign prod_rnd = prod + HALF16;
  assign term     = sat32(58'(prod_rnd >>> 16));
  assign acc_upd  = sat32(58'(acc[sel]) + 58'(term));

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      dpos[c] = 33'(cur[c]) - 33'(prev[c]);
      nxt[c]  = sat32(58'(cur[c]) + ((md[c] + HALF24) >>> 24) + ((mp[c] + HALF24) >>> 24));
    end
  end

  // multiplier stage registers
  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod <= 57'(vec) * 57'(im_s);
    end
    if (ctl.mul_en) begin
      for (int c = 0; c < 2; c++) begin
        md[c] <= 58'(dpos[c]) * 58'(DAMP_S);
        mp[c] <= 58'(acc[c]) * 58'(dt2_s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur  <= '{default: '0};
      prev <= '{default: '0};
      acc  <= '{default: '0};
    end else if (ctl.upd_en && ctl.cmd == dvps_pkg::CMD_RESTORE) begin
      cur[0]  <= init;
      prev[0] <= init;
      cur[1]  <= '0;
      prev[1] <= '0;
      acc     <= '{default: '0};
    end else if (ctl.upd_en && ctl.cmd == dvps_pkg::CMD_STEP && !ctl.pinned) begin
      for (int c = 0; c < 2; c++) begin
        prev[c] <= cur[c];
        cur[c]  <= nxt[c];
        acc[c]  <= '0;
      end
    end else if (ctl.mul_en && is_force && !ctl.pinned) begin
      acc[sel] <= acc_upd;
    end
  end

  assign pos  = cur[0];
  assign grad = cur[1];

endmodule

`default_nettype wire

/* rtl/dvps_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

// Gathers the lane results into one output beat and holds it until taken.
module dvps_merge (
  input  wire logic                                                  clk,
  input  wire logic                                                  rst,
  input  wire logic                                                  load,
  input  wire logic [dvps_pkg::MAX_AXES-1:0][dvps_pkg::WORD_W-1:0]   pos,
  input  wire logic [dvps_pkg::MAX_AXES-1:0][dvps_pkg::WORD_W-1:0]   grad,
  output logic                                                       free,
  output logic                                                       m_axis_tvalid,
  input  wire logic                                                  m_axis_tready,
  // pos_x, pos_y, pos_z, grad_x, grad_y, grad_z
  output logic [dvps_pkg::OUT_W-1:0]                                 m_axis_tdata
);

  assign free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {grad, pos};
    end
  end

endmodule

`default_nettype wire

/* rtl/damped_verlet_particle_step.sv */
// Damped position-Verlet step for one particle, signed Q16.16 per axis.
// Input stream: s_axis_tuser carries the command (0 add force, 1 add gradient
// force, 2 time step, 3 restore), s_axis_tdata the vector and time step.
// Output stream: one beat per input beat with position and gradient after it.
// Config: cfg_we/cfg_index/cfg_data write init_x/y/z, pinned, inv_mass; only
// write while no beat is in flight. Index values above 4 are ignored.
// Processing: after the input beat is taken come dt^2 and force product, lane
// multiplies, state update and output load, in order; the result beat goes valid
// after the load. The dependent multiply chain in each lane keeps further input
// beats out until the result is loaded, in which cycle the next one is taken.
// Each used axis (a < AXES) has its own lane; the output register merges them.
// Reset: state clears to zero (initial position 0), inv_mass to 1.0, pinned 0.
// Stall: a result waiting on m_axis_tready holds; one further input beat may
// be taken and processed, then the block waits with s_axis_tready low.
`timescale 1ns / 1ps
`default_nettype none

module damped_verlet_particle_step #(
  parameter int AXES = dvps_pkg::AXES_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // vec_x, vec_y, vec_z, time_step
  input  wire logic [dvps_pkg::IN_W-1:0]         s_axis_tdata,
  // command
  input  wire logic [1:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // pos_x, pos_y, pos_z, grad_x, grad_y, grad_z
  output logic [dvps_pkg::OUT_W-1:0]             m_axis_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [dvps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dvps_pkg::CFG_W-1:0]        cfg_data
);

  localparam int NA = dvps_pkg::MAX_AXES;
  localparam int W  = dvps_pkg::WORD_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DT   = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [NA-1:0][W-1:0]            init_r;
  logic                            pinned_r;
  logic [dvps_pkg::MASS_W-1:0]     inv_mass_r;
  dvps_pkg::cmd_t                  cmd_r;
  logic [NA-1:0][W-1:0]            vec_r;
  logic [dvps_pkg::DT_W-1:0]       dt_r;
  logic [dvps_pkg::DT_W-1:0]       dt2_r;
  logic [NA-1:0][W-1:0]            pos_all;
  logic [NA-1:0][W-1:0]            grad_all;
  dvps_pkg::lane_ctl_t             ctl;
  logic                            out_free;
  logic                            load;
  logic                            accept;

  assign load          = (state == ST_OUT) && out_free;
  assign s_axis_tready = (state == ST_IDLE) || load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_DT;
      ST_DT:   state_next = ST_MUL;
      ST_MUL:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_OUT;
      ST_OUT: begin
        if (load) state_next = accept ? ST_DT : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_r     <= '0;
      pinned_r   <= 1'b0;
      inv_mass_r <= dvps_pkg::INV_MASS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dvps_pkg::REG_INIT_X:   init_r[0]  <= cfg_data;
        dvps_pkg::REG_INIT_Y:   init_r[1]  <= cfg_data;
        dvps_pkg::REG_INIT_Z:   init_r[2]  <= cfg_data;
        dvps_pkg::REG_PINNED:   pinned_r   <= cfg_data[0];
        dvps_pkg::REG_INV_MASS: inv_mass_r <= cfg_data[dvps_pkg::MASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= dvps_pkg::cmd_t'(s_axis_tuser);
      vec_r <= s_axis_tdata[NA*W-1:0];
      dt_r  <= s_axis_tdata[dvps_pkg::IN_W-1:NA*W];
    end
    // dt^2 rounded to Q0.24
    if (state == ST_DT) begin
      dt2_r <= dvps_pkg::DT_W'((48'(dt_r) * 48'(dt_r) + 48'd8388608) >> 24);
    end
  end

  assign ctl.prod_en = (state == ST_DT);
  assign ctl.mul_en  = (state == ST_MUL);
  assign ctl.upd_en  = (state == ST_UPD);
  assign ctl.cmd     = cmd_r;
  assign ctl.pinned  = pinned_r;

  for (genvar a = 0; a < NA; a++) begin : g_axis
    if (a < AXES) begin : g_lane
      dvps_lane u_lane (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .vec      (vec_r[a]),
        .inv_mass (inv_mass_r),
        .dt2      (dt2_r),
        .init     (init_r[a]),
        .pos      (pos_all[a]),
        .grad     (grad_all[a])
      );
    end else begin : g_unused
      assign pos_all[a]  = '0;
      assign grad_all[a] = '0;
    end
  end

  dvps_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .pos           (pos_all),
    .grad          (grad_all),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DT)
    else $error("accepted beat did not start processing");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) && !out_free |=> state == ST_OUT)
    else $error("left output state while result register busy");

  a_upd_to_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPD |=> state == ST_OUT)
    else $error("update not followed by output load");

  a_pinned_frozen: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) && pinned_r && (cmd_r != dvps_pkg::CMD_RESTORE)
    |=> $stable(pos_all) && $stable(grad_all))
    else $error("pinned particle moved");

  a_restore_grad: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) && (cmd_r == dvps_pkg::CMD_RESTORE) |=> grad_all == '0)
    else $error("restore left gradient nonzero");
`endif

endmodule

`default_nettype wire
